FILE: rtl/yrgb_pkg.sv
// yrgb_pkg: shared types, colour matrix constants and arithmetic helpers
// for the yuv420 block to rgb pipeline; no dependencies
`timescale 1ns / 1ps

package yrgb_pkg;

  // fixed point widths: products and sums carry 16 fraction bits
  localparam int TERM_W  = 27;
  localparam int COEF_W  = 19;
  localparam int OPND_W  = 9;
  localparam int PROD_W  = COEF_W + OPND_W;
  localparam int FRAC_W  = 16;
  localparam int PIX_N   = 4;
  localparam int CH_N    = 3;

  // pixel positions inside the 2x2 block
  localparam int PIX_TL  = 0;
  localparam int PIX_TR  = 1;
  localparam int PIX_BL  = 2;
  localparam int PIX_BR  = 3;

  // colour channel positions inside one pixel
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // bt.601 style coefficients in signed 3.16
  localparam logic signed [COEF_W-1:0] LUMA_GAIN    = 19'sd76310;
  localparam logic signed [COEF_W-1:0] RED_FROM_V   = 19'sd104635;
  localparam logic signed [COEF_W-1:0] GREEN_FROM_U = -19'sd25690;
  localparam logic signed [COEF_W-1:0] GREEN_FROM_V = -19'sd53294;
  localparam logic signed [COEF_W-1:0] BLUE_FROM_U  = 19'sd132278;

  localparam logic [7:0] CHROMA_MID = 8'd128;
  localparam logic [7:0] LUMA_FLOOR = 8'd16;

  // saturation bounds of a colour sum
  localparam logic signed [TERM_W-1:0] SUM_LOW_MAX  = 27'sh000ffff;
  localparam logic signed [TERM_W-1:0] SUM_HIGH_MAX = 27'sh0ffffff;
  localparam logic [7:0]               BYTE_MAX     = 8'hff;
  localparam logic [7:0]               BYTE_MIN     = 8'h00;

  typedef logic signed [TERM_W-1:0] term_t;

  // one accepted input beat
  typedef struct packed {
    logic [PIX_N-1:0][7:0] luma;
    logic [7:0]            u;
    logic [7:0]            v;
  } blk_in_t;

  // after offset removal and luma floor
  typedef struct packed {
    logic [PIX_N-1:0][7:0] luma_off;
    logic [OPND_W-1:0]     du;
    logic [OPND_W-1:0]     dv;
  } prep_t;

  // after the multipliers
  typedef struct packed {
    logic [PIX_N-1:0][TERM_W-1:0] luma_term;
    logic [TERM_W-1:0]            red_term;
    logic [TERM_W-1:0]            green_u;
    logic [TERM_W-1:0]            green_v;
    logic [TERM_W-1:0]            blue_term;
  } prod_t;

  // chroma terms complete
  typedef struct packed {
    logic [PIX_N-1:0][TERM_W-1:0] luma_term;
    logic [TERM_W-1:0]            red_term;
    logic [TERM_W-1:0]            green_term;
    logic [TERM_W-1:0]            blue_term;
  } mix_t;

  // saturated result beat, [pixel][channel]
  typedef struct packed {
    logic [PIX_N-1:0][CH_N-1:0][7:0] px;
  } rgb_t;

  // coefficient times a small signed operand, fits the term width
  function automatic term_t mul_term(input logic signed [COEF_W-1:0] k,
                                     input logic signed [OPND_W-1:0] d);
    logic signed [PROD_W-1:0] p;
    p = k * d;
    return term_t'(p[TERM_W-1:0]);
  endfunction

  // add luma and chroma terms, then clip to one byte
  function automatic logic [7:0] clip_add(input term_t a, input term_t b);
    term_t s;
    s = a + b;
    if (s > SUM_HIGH_MAX) begin
      return BYTE_MAX;
    end else if (s <= SUM_LOW_MAX) begin
      return BYTE_MIN;
    end else begin
      return s[FRAC_W+7:FRAC_W];
    end
  endfunction

endpackage

FILE: rtl/yrgb_ifs.sv
// yrgb_in_if and yrgb_out_if: valid/ready channels of the block converter
// payload fields are plain 8 bit unsigned samples; no dependencies
`timescale 1ns / 1ps

interface yrgb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_top_left;
  logic [7:0] luma_top_right;
  logic [7:0] luma_bottom_left;
  logic [7:0] luma_bottom_right;
  logic [7:0] chroma_u;
  logic [7:0] chroma_v;

  modport source (
    output valid, luma_top_left, luma_top_right, luma_bottom_left,
           luma_bottom_right, chroma_u, chroma_v,
    input  ready
  );

  modport sink (
    input  valid, luma_top_left, luma_top_right, luma_bottom_left,
           luma_bottom_right, chroma_u, chroma_v,
    output ready
  );
endinterface

interface yrgb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_top_left;
  logic [7:0] green_top_left;
  logic [7:0] blue_top_left;
  logic [7:0] red_top_right;
  logic [7:0] green_top_right;
  logic [7:0] blue_top_right;
  logic [7:0] red_bottom_left;
  logic [7:0] green_bottom_left;
  logic [7:0] blue_bottom_left;
  logic [7:0] red_bottom_right;
  logic [7:0] green_bottom_right;
  logic [7:0] blue_bottom_right;

  modport source (
    output valid,
           red_top_left, green_top_left, blue_top_left,
           red_top_right, green_top_right, blue_top_right,
           red_bottom_left, green_bottom_left, blue_bottom_left,
           red_bottom_right, green_bottom_right, blue_bottom_right,
    input  ready
  );

  modport sink (
    input  valid,
           red_top_left, green_top_left, blue_top_left,
           red_top_right, green_top_right, blue_top_right,
           red_bottom_left, green_bottom_left, blue_bottom_left,
           red_bottom_right, green_bottom_right, blue_bottom_right,
    output ready
  );
endinterface

FILE: rtl/yrgb_prep.sv
// yrgb_prep: first pipeline stage, chroma offset removal and luma floor
// depends on yrgb_pkg
`timescale 1ns / 1ps

module yrgb_prep
  import yrgb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    up_valid,
  output logic    up_ready,
  input  blk_in_t up_data,
  output logic    dn_valid,
  input  logic    dn_ready,
  output prep_t   dn_data
);

  logic  s1_v_r;
  prep_t s1_r;
  prep_t s1_nxt;

  // stage may load when empty or draining
  assign up_ready = !s1_v_r || dn_ready;

  // offsets: chroma centred on zero, luma floored at sixteen
  always_comb begin
    for (int p = 0; p < PIX_N; p++) begin
      if (up_data.luma[p] >= LUMA_FLOOR) begin
        s1_nxt.luma_off[p] = up_data.luma[p] - LUMA_FLOOR;
      end else begin
        s1_nxt.luma_off[p] = 8'd0;
      end
    end
    s1_nxt.du = {1'b0, up_data.u} - {1'b0, CHROMA_MID};
    s1_nxt.dv = {1'b0, up_data.v} - {1'b0, CHROMA_MID};
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (up_ready) begin
      s1_v_r <= up_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      s1_r <= s1_nxt;
    end
  end

  assign dn_valid = s1_v_r;
  assign dn_data  = s1_r;

endmodule

FILE: rtl/yrgb_mult.sv
// yrgb_mult: second pipeline stage, one multiplier per luma and chroma term
// depends on yrgb_pkg
`timescale 1ns / 1ps

module yrgb_mult
  import yrgb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  prep_t up_data,
  output logic  dn_valid,
  input  logic  dn_ready,
  output prod_t dn_data
);

  logic  s2_v_r;
  prod_t s2_r;
  prod_t s2_nxt;

  assign up_ready = !s2_v_r || dn_ready;

  // eight independent 19x9 products
  always_comb begin
    for (int p = 0; p < PIX_N; p++) begin
      s2_nxt.luma_term[p] = mul_term(LUMA_GAIN, $signed({1'b0, up_data.luma_off[p]}));
    end
    s2_nxt.red_term  = mul_term(RED_FROM_V,   $signed(up_data.dv));
    s2_nxt.green_u   = mul_term(GREEN_FROM_U, $signed(up_data.du));
    s2_nxt.green_v   = mul_term(GREEN_FROM_V, $signed(up_data.dv));
    s2_nxt.blue_term = mul_term(BLUE_FROM_U,  $signed(up_data.du));
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (up_ready) begin
      s2_v_r <= up_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      s2_r <= s2_nxt;
    end
  end

  assign dn_valid = s2_v_r;
  assign dn_data  = s2_r;

endmodule

FILE: rtl/yrgb_mix.sv
// yrgb_mix: third and fourth pipeline stages, green term sum, then colour
// sums with saturation into the output register; depends on yrgb_pkg
`timescale 1ns / 1ps

module yrgb_mix
  import yrgb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  prod_t up_data,
  output logic  dn_valid,
  input  logic  dn_ready,
  output rgb_t  dn_data
);

  logic s3_v_r;
  logic s3_ready;
  mix_t s3_r;
  mix_t s3_nxt;
  logic s4_v_r;
  rgb_t s4_r;
  rgb_t s4_nxt;

  assign s3_ready = !s4_v_r || dn_ready;
  assign up_ready = !s3_v_r || s3_ready;

  // green term from both chroma products
  always_comb begin
    s3_nxt.luma_term  = up_data.luma_term;
    s3_nxt.red_term   = up_data.red_term;
    s3_nxt.green_term = $signed(up_data.green_u) + $signed(up_data.green_v);
    s3_nxt.blue_term  = up_data.blue_term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (up_ready) begin
      s3_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      s3_r <= s3_nxt;
    end
  end

  // per pixel colour sums, clipped to a byte
  always_comb begin
    for (int p = 0; p < PIX_N; p++) begin
      s4_nxt.px[p][CH_RED]   = clip_add(s3_r.luma_term[p], s3_r.red_term);
      s4_nxt.px[p][CH_GREEN] = clip_add(s3_r.luma_term[p], s3_r.green_term);
      s4_nxt.px[p][CH_BLUE]  = clip_add(s3_r.luma_term[p], s3_r.blue_term);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (s3_ready) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s3_v_r) begin
      s4_r <= s4_nxt;
    end
  end

  assign dn_valid = s4_v_r;
  assign dn_data  = s4_r;

  // stalled output beat is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r && !dn_ready |=> s4_v_r && $stable(s4_r))
    else $error("output stage lost or changed a stalled beat");

  // stalled stage three beat is held
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && !s3_ready |=> s3_v_r && $stable(s3_r))
    else $error("stage three lost or changed a stalled beat");

  // a beat leaving stage three lands in the output register
  a_s3_move: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && s3_ready |=> s4_v_r)
    else $error("beat vanished between stage three and output");

endmodule

FILE: rtl/yuv420_block_to_rgb.sv
// yuv420_block_to_rgb: top level of the 2x2 block yuv to rgb converter
// depends on yrgb_pkg, yrgb_ifs, yrgb_prep, yrgb_mult, yrgb_mix
//
// usage
//   in_blk carries one 2x2 block per beat: four luma samples and the shared
//   u and v samples. out_blk carries the twelve saturated colour bytes of
//   that block, in the same order as the blocks came in.
//   the datapath is four register stages: offset and luma floor, products,
//   green term sum, then colour sums with saturation into the output
//   register. an accepted block moves through these stages in that order
//   and is offered on out_blk from the output register, where the
//   receiver can take it.
//   one block is taken every cycle while the receiver keeps ready high; the
//   four stages each hold one block.
//   when out_blk stalls, each stage holds its beat and in_blk.ready drops
//   once every stage holds a block; nothing is dropped or repeated.
//   reset clears all stage valid bits, so out_blk.valid is low after reset.
`timescale 1ns / 1ps

module yuv420_block_to_rgb
  import yrgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  yrgb_in_if.sink     in_blk,
  yrgb_out_if.source  out_blk
);

  blk_in_t in_data;
  logic    prep_valid;
  logic    prep_ready;
  prep_t   prep_data;
  logic    mult_valid;
  logic    mult_ready;
  prod_t   mult_data;
  rgb_t    rgb_data;

  // input beat into the stage format
  always_comb begin
    in_data.luma[PIX_TL] = in_blk.luma_top_left;
    in_data.luma[PIX_TR] = in_blk.luma_top_right;
    in_data.luma[PIX_BL] = in_blk.luma_bottom_left;
    in_data.luma[PIX_BR] = in_blk.luma_bottom_right;
    in_data.u            = in_blk.chroma_u;
    in_data.v            = in_blk.chroma_v;
  end

  yrgb_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_blk.valid),
    .up_ready (in_blk.ready),
    .up_data  (in_data),
    .dn_valid (prep_valid),
    .dn_ready (prep_ready),
    .dn_data  (prep_data)
  );

  yrgb_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prep_valid),
    .up_ready (prep_ready),
    .up_data  (prep_data),
    .dn_valid (mult_valid),
    .dn_ready (mult_ready),
    .dn_data  (mult_data)
  );

  yrgb_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mult_valid),
    .up_ready (mult_ready),
    .up_data  (mult_data),
    .dn_valid (out_blk.valid),
    .dn_ready (out_blk.ready),
    .dn_data  (rgb_data)
  );

  // result beat onto the output channel
  assign out_blk.red_top_left       = rgb_data.px[PIX_TL][CH_RED];
  assign out_blk.green_top_left     = rgb_data.px[PIX_TL][CH_GREEN];
  assign out_blk.blue_top_left      = rgb_data.px[PIX_TL][CH_BLUE];
  assign out_blk.red_top_right      = rgb_data.px[PIX_TR][CH_RED];
  assign out_blk.green_top_right    = rgb_data.px[PIX_TR][CH_GREEN];
  assign out_blk.blue_top_right     = rgb_data.px[PIX_TR][CH_BLUE];
  assign out_blk.red_bottom_left    = rgb_data.px[PIX_BL][CH_RED];
  assign out_blk.green_bottom_left  = rgb_data.px[PIX_BL][CH_GREEN];
  assign out_blk.blue_bottom_left   = rgb_data.px[PIX_BL][CH_BLUE];
  assign out_blk.red_bottom_right   = rgb_data.px[PIX_BR][CH_RED];
  assign out_blk.green_bottom_right = rgb_data.px[PIX_BR][CH_GREEN];
  assign out_blk.blue_bottom_right  = rgb_data.px[PIX_BR][CH_BLUE];

endmodule

FILE: verif/yuv420_block_to_rgb_tb.sv
// yuv420_block_to_rgb_tb: self-checking bench for the 2x2 block yuv to rgb converter
// drives yrgb_in_if beats and checks yrgb_out_if beats against a colour predictor
// depends on yrgb_pkg, yrgb_ifs and yuv420_block_to_rgb
`timescale 1ns / 1ps

module yuv420_block_to_rgb_tb
  import yrgb_pkg::*;
();

  // predicts the colour bytes of each accepted block and checks result beats in order
  class colour_block_board;
    localparam longint K_LUMA      = 76310;
    localparam longint K_RED_V     = 104635;
    localparam longint K_GREEN_U   = -25690;
    localparam longint K_GREEN_V   = -53294;
    localparam longint K_BLUE_U    = 132278;
    localparam longint CHROMA_BIAS = 128;
    localparam longint LUMA_BLACK  = 16;
    localparam longint SAT_FLOOR   = 65535;
    localparam longint SAT_TOP     = 16777215;

    rgb_t        rgb_due[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // clip a 16.16 colour sum to one byte
    function logic [7:0] clamp_byte(input longint s);
      if (s > SAT_TOP) begin
        return 8'hff;
      end else if (s <= SAT_FLOOR) begin
        return 8'h00;
      end
      return s[23:16];
    endfunction

    function rgb_t convert_block(input blk_in_t b);
      rgb_t   res;
      longint du, dv, red_t, green_t, blue_t, luma_t;
      int     p;
      du      = longint'(b.u) - CHROMA_BIAS;
      dv      = longint'(b.v) - CHROMA_BIAS;
      red_t   = K_RED_V * dv;
      green_t = K_GREEN_U * du + K_GREEN_V * dv;
      blue_t  = K_BLUE_U * du;
      for (p = 0; p < PIX_N; p++) begin
        // dark luma counts as black
        luma_t = longint'(b.luma[p]) - LUMA_BLACK;
        if (luma_t < 0) begin
          luma_t = 0;
        end
        luma_t = luma_t * K_LUMA;
        res.px[p][CH_RED]   = clamp_byte(luma_t + red_t);
        res.px[p][CH_GREEN] = clamp_byte(luma_t + green_t);
        res.px[p][CH_BLUE]  = clamp_byte(luma_t + blue_t);
      end
      return res;
    endfunction

    function void note_block(input blk_in_t b);
      rgb_due.push_back(convert_block(b));
    endfunction

    function void check_block(input rgb_t got);
      string pix_names[PIX_N] = '{"top_left", "top_right", "bottom_left", "bottom_right"};
      string ch_names[CH_N]   = '{"red", "green", "blue"};
      rgb_t  want;
      int    p, c;
      if (rgb_due.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %h", $time, got);
        mismatches++;
        return;
      end
      want = rgb_due.pop_front();
      for (p = 0; p < PIX_N; p++) begin
        for (c = 0; c < CH_N; c++) begin
          if (got.px[p][c] !== want.px[p][c]) begin
            $display("%0t: %s_%s expected %0d got %0d", $time, ch_names[c], pix_names[p],
                     want.px[p][c], got.px[p][c]);
            mismatches++;
          end
        end
      end
    endfunction

    function int pending();
      return rgb_due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;

  colour_block_board board = new();

  yrgb_in_if  in_blk();
  yrgb_out_if out_blk();

  yuv420_block_to_rgb u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_blk  (in_blk),
    .out_blk (out_blk)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic blk_in_t make_block(input logic [7:0] tl, input logic [7:0] tr,
                                         input logic [7:0] bl, input logic [7:0] br,
                                         input logic [7:0] u, input logic [7:0] v);
    blk_in_t b;
    b.luma[PIX_TL] = tl;
    b.luma[PIX_TR] = tr;
    b.luma[PIX_BL] = bl;
    b.luma[PIX_BR] = br;
    b.u = u;
    b.v = v;
    return b;
  endfunction

  // uniform sample, leaning now and then towards the thresholds
  function automatic logic [7:0] pick_sample();
    logic [7:0] edge_vals[10] = '{8'd0, 8'd15, 8'd16, 8'd17, 8'd127,
                                  8'd128, 8'd129, 8'd235, 8'd240, 8'd255};
    if ($urandom_range(3) == 0) begin
      return edge_vals[$urandom_range(9)];
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic blk_in_t random_block();
    return make_block(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                      pick_sample(), pick_sample());
  endfunction

  task automatic drive_payload(input blk_in_t b);
    in_blk.luma_top_left     <= b.luma[PIX_TL];
    in_blk.luma_top_right    <= b.luma[PIX_TR];
    in_blk.luma_bottom_left  <= b.luma[PIX_BL];
    in_blk.luma_bottom_right <= b.luma[PIX_BR];
    in_blk.chroma_u          <= b.u;
    in_blk.chroma_v          <= b.v;
  endtask

  // entered and left at a falling edge
  task automatic send_block(input blk_in_t b);
    // idle cycles carry junk payload
    while ($urandom_range(99) < send_idle_pct) begin
      in_blk.valid <= 1'b0;
      drive_payload(random_block());
      @(negedge clk);
    end
    in_blk.valid <= 1'b1;
    drive_payload(b);
    do @(posedge clk); while (!in_blk.ready);
    board.note_block(b);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_blk.valid <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
  endtask

  task automatic run_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_block(random_block());
  endtask

  function automatic rgb_t sample_out();
    rgb_t r;
    r.px[PIX_TL][CH_RED]   = out_blk.red_top_left;
    r.px[PIX_TL][CH_GREEN] = out_blk.green_top_left;
    r.px[PIX_TL][CH_BLUE]  = out_blk.blue_top_left;
    r.px[PIX_TR][CH_RED]   = out_blk.red_top_right;
    r.px[PIX_TR][CH_GREEN] = out_blk.green_top_right;
    r.px[PIX_TR][CH_BLUE]  = out_blk.blue_top_right;
    r.px[PIX_BL][CH_RED]   = out_blk.red_bottom_left;
    r.px[PIX_BL][CH_GREEN] = out_blk.green_bottom_left;
    r.px[PIX_BL][CH_BLUE]  = out_blk.blue_bottom_left;
    r.px[PIX_BR][CH_RED]   = out_blk.red_bottom_right;
    r.px[PIX_BR][CH_GREEN] = out_blk.green_bottom_right;
    r.px[PIX_BR][CH_BLUE]  = out_blk.blue_bottom_right;
    return r;
  endfunction

  // result side: ready at the falling edge, beat taken at the rising edge
  initial begin
    out_blk.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_blk.ready <= ($urandom_range(99) >= recv_stall_pct);
      @(posedge clk);
      if (rst_n && out_blk.valid && out_blk.ready) begin
        board.check_block(sample_out());
      end
    end
  end

  // stimulus
  initial begin
    rst_n                    = 1'b0;
    in_blk.valid             = 1'b0;
    in_blk.luma_top_left     = 8'd0;
    in_blk.luma_top_right    = 8'd0;
    in_blk.luma_bottom_left  = 8'd0;
    in_blk.luma_bottom_right = 8'd0;
    in_blk.chroma_u          = 8'd0;
    in_blk.chroma_v          = 8'd0;
    send_idle_pct            = 0;
    recv_stall_pct           = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, dark luma, sums at both clip bounds
    send_block(make_block(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_block(make_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    send_block(make_block(8'd15, 8'd16, 8'd17, 8'd235, 8'd128, 8'd128));
    send_block(make_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128));
    send_block(make_block(8'd0, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128));
    send_block(make_block(8'd16, 8'd100, 8'd200, 8'd255, 8'd128, 8'd255));
    send_block(make_block(8'd16, 8'd100, 8'd200, 8'd255, 8'd128, 8'd0));
    send_block(make_block(8'd16, 8'd100, 8'd200, 8'd255, 8'd255, 8'd128));
    send_block(make_block(8'd16, 8'd100, 8'd200, 8'd255, 8'd0, 8'd128));
    send_block(make_block(8'd16, 8'd60, 8'd180, 8'd255, 8'd0, 8'd0));
    send_block(make_block(8'd16, 8'd60, 8'd180, 8'd255, 8'd255, 8'd255));
    send_block(make_block(8'd17, 8'd17, 8'd18, 8'd18, 8'd128, 8'd128));
    send_block(make_block(8'd16, 8'd16, 8'd16, 8'd16, 8'd129, 8'd129));
    send_block(make_block(8'd16, 8'd16, 8'd17, 8'd17, 8'd127, 8'd127));
    send_block(make_block(8'd0, 8'd5, 8'd10, 8'd15, 8'd200, 8'd60));
    send_block(make_block(8'haa, 8'h55, 8'haa, 8'h55, 8'h55, 8'haa));
    send_block(make_block(8'h80, 8'h7f, 8'h7f, 8'h80, 8'h7f, 8'h80));
    send_block(make_block(8'd235, 8'd235, 8'd235, 8'd235, 8'd240, 8'd16));
    send_block(make_block(8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd240));
    send_block(make_block(8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255));
    hold_until_drained();

    // random phases with varying idle and stall
    run_random(240, 0, 0);
    hold_until_drained();
    run_random(240, 73, 0);
    run_random(235, 0, 73);
    hold_until_drained();
    run_random(235, 20, 20);

    // drain, then give the pipeline time to show any stray beat
    hold_until_drained();
    repeat (8) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
